>>> rtl/priority_periodic_task_scheduler_assert.svh
// Assertion macros shared by the task scheduler RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef PRIORITY_PERIODIC_TASK_SCHEDULER_ASSERT_SVH
`define PRIORITY_PERIODIC_TASK_SCHEDULER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PPTS_ASSERT_HOLDS(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PPTS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/ppts_pkg.sv
// Shared types, widths and codes for the priority periodic task scheduler.
// Used by every RTL module of the block but ppts_ram; depends on nothing else.
package ppts_pkg;

	// Default table shape.
	localparam int DEF_LEVELS = 4;
	localparam int DEF_SLOTS  = 4;

	// Field widths.
	localparam int ACTION_W   = 3;
	localparam int ID_W       = 8;
	localparam int PRIO_W     = 4;
	localparam int TIME_W     = 16;
	localparam int STEP_W     = 6;
	localparam int RUN_LVL_W  = 2;
	localparam int RUN_SLOT_W = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 6;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_TICK_STEP = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PREEMPT   = 2'd1;

	// Configuration reset values.
	localparam logic [STEP_W-1:0] TICK_STEP_RST = 6'd1;
	localparam logic              PREEMPT_RST   = 1'b0;

	// Result status codes.
	localparam logic STATUS_OK        = 1'b0;
	localparam logic STATUS_NOT_ADDED = 1'b1;

	// Command codes.
	typedef enum logic [ACTION_W-1:0] {
		ACT_ADD     = 3'd0,
		ACT_DELETE  = 3'd1,
		ACT_SUSPEND = 3'd2,
		ACT_RESUME  = 3'd3,
		ACT_TICK    = 3'd4
	} action_t;

	// Task state held in each slot.
	typedef enum logic [1:0] {
		SLOT_READY     = 2'd0,
		SLOT_WAITING   = 2'd1,
		SLOT_SUSPENDED = 2'd2
	} slot_state_t;

	// One table slot as stored in the slot memory.
	typedef struct packed {
		logic              used;
		logic [ID_W-1:0]   id;
		slot_state_t       st;
		logic [TIME_W-1:0] period;
		logic [TIME_W-1:0] delay;
	} slot_rec_t;

	localparam int        REC_W     = $bits(slot_rec_t);
	localparam slot_rec_t REC_RESET = '0;

	// One result beat.
	typedef struct packed {
		logic                  status;
		logic                  dispatched;
		logic [ID_W-1:0]       run_id;
		logic [RUN_LVL_W-1:0]  run_level;
		logic [RUN_SLOT_W-1:0] run_slot;
		logic                  last;
	} rsp_beat_t;

	// Request to the shared delay subtractor.
	typedef struct packed {
		logic              sel_period;
		logic [TIME_W-1:0] period;
		logic [TIME_W-1:0] delay;
		logic [STEP_W-1:0] step;
	} alu_req_t;

	// Answer of the shared delay subtractor.
	typedef struct packed {
		logic [TIME_W-1:0] diff;
		logic              zero;
	} alu_rsp_t;

endpackage

>>> rtl/ppts_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Holds the slot records of the task scheduler; no package dependencies.
module ppts_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port and registered read port; read data holds while re is low.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/ppts_alu.sv
// Shared delay unit: subtracts the tick step from a period or a delay.
// Depends on ppts_pkg for the request and answer structs.
module ppts_alu import ppts_pkg::*; (
	input  alu_req_t req,
	output alu_rsp_t rsp
);

	logic [TIME_W-1:0] operand;

	// A dispatch reloads from the period, a waiting slot counts its delay down.
	assign operand  = req.sel_period ? req.period : req.delay;
	assign rsp.diff = operand - TIME_W'(req.step);
	assign rsp.zero = (rsp.diff == '0);

endmodule

>>> rtl/ppts_ctrl.sv
// Sequencer of the task scheduler: walks the slot table one slot per cycle unless a dispatch beat is blocked.
// Depends on ppts_pkg and the assertion macro header.
`include "priority_periodic_task_scheduler_assert.svh"

module ppts_ctrl import ppts_pkg::*; #(
	parameter int LEVELS = DEF_LEVELS,
	parameter int SLOTS  = DEF_SLOTS,
	localparam int NSLOT = LEVELS * SLOTS,
	localparam int IW    = (NSLOT > 1) ? $clog2(NSLOT) : 1
) (
	input  logic                clk,
	input  logic                arst_n,
	// Command beat
	input  logic                cmd_valid,
	output logic                cmd_stall,
	input  logic [ACTION_W-1:0] action,
	input  logic [ID_W-1:0]     task_id,
	input  logic [PRIO_W-1:0]   priority_req,
	input  logic [TIME_W-1:0]   period,
	input  logic [TIME_W-1:0]   first_delay,
	// Configuration
	input  logic [STEP_W-1:0]   tick_step,
	input  logic                preempt,
	// Result beat toward the output register
	output logic                beat_valid,
	output rsp_beat_t           beat,
	input  logic                beat_take,
	// Slot memory
	output logic                ram_we,
	output logic [IW-1:0]       ram_waddr,
	output logic [REC_W-1:0]    ram_wdata,
	output logic                ram_re,
	output logic [IW-1:0]       ram_raddr,
	input  logic [REC_W-1:0]    ram_rdata,
	// Shared delay unit
	output alu_req_t            alu_req,
	input  alu_rsp_t            alu_rsp
);

	localparam int LW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
	localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam logic [IW-1:0]     IDX_LAST = IW'(NSLOT - 1);
	localparam logic [SW-1:0]     SL_LAST  = SW'(SLOTS - 1);
	localparam logic [PRIO_W:0]   PRIO_LIM = (PRIO_W + 1)'(LEVELS);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_PEND,
		S_TICK_END,
		S_REPLY
	} state_t;

	state_t                state_q;
	logic [ACTION_W-1:0]   act_q;
	logic [ID_W-1:0]       id_q;
	logic [TIME_W-1:0]     per_q;
	logic [TIME_W-1:0]     fd_q;
	logic                  status_q;
	logic [IW-1:0]         idx_q;
	logic [LW-1:0]         lvl_q;
	logic [SW-1:0]         sl_q;
	logic                  found_q;
	logic [LW-1:0]         running_level_q;
	logic                  pend_valid_q;
	logic [IW-1:0]         pend_idx_q;
	logic [LW-1:0]         pend_lvl_q;
	logic [SW-1:0]         pend_sl_q;
	logic                  held_valid_q;
	logic [ID_W-1:0]       held_id_q;
	logic [LW-1:0]         held_lvl_q;
	logic [SW-1:0]         held_sl_q;
	logic                  wr_q [NSLOT];
	logic                  rd_wr_q;

	slot_rec_t             rec;
	slot_rec_t             rec_new;
	logic                  prio_ok;
	logic [IW-1:0]         add_base;
	logic [IW-1:0]         start_idx;
	logic                  start_read;
	logic                  scan_last;
	logic                  scan_go;
	logic                  hit;
	logic                  emit_held;

	// Entries never written read as the reset record.
	assign rec = rd_wr_q ? slot_rec_t'(ram_rdata) : REC_RESET;

	assign cmd_stall = (state_q != S_IDLE);
	assign prio_ok   = ({1'b0, priority_req} < PRIO_LIM);
	assign add_base  = IW'(32'(priority_req) * SLOTS);
	assign scan_last = (act_q == ACT_ADD) ? (sl_q == SL_LAST) : (idx_q == IDX_LAST);
	assign ram_waddr = idx_q;
	assign ram_wdata = rec_new;

	// First slot read for a new command.
	always_comb begin
		start_idx  = '0;
		start_read = 1'b1;
		case (action)
			ACT_ADD: begin
				start_idx  = add_base;
				start_read = prio_ok;
			end
			ACT_DELETE, ACT_SUSPEND, ACT_RESUME: begin
				start_idx = '0;
			end
			ACT_TICK: begin
				start_idx = pend_valid_q ? pend_idx_q : '0;
			end
			default: begin
				start_read = 1'b0;
			end
		endcase
	end

	// Per-slot decisions, memory strobes and result beats.
	always_comb begin
		ram_re             = 1'b0;
		ram_raddr          = IW'(idx_q + IW'(1));
		ram_we             = 1'b0;
		rec_new            = rec;
		beat_valid         = 1'b0;
		beat               = '0;
		beat.last          = 1'b1;
		hit                = 1'b0;
		emit_held          = 1'b0;
		scan_go            = 1'b1;
		alu_req.sel_period = (state_q == S_PEND) || (rec.st == SLOT_READY);
		alu_req.period     = rec.period;
		alu_req.delay      = rec.delay;
		alu_req.step       = tick_step;
		case (state_q)
			S_IDLE: begin
				ram_re    = cmd_valid && start_read;
				ram_raddr = start_idx;
			end
			S_SCAN: begin
				case (act_q)
					ACT_ADD: begin
						if (!rec.used) begin
							hit            = 1'b1;
							ram_we         = 1'b1;
							rec_new.used   = 1'b1;
							rec_new.id     = id_q;
							rec_new.st     = (fd_q == '0) ? SLOT_READY : SLOT_WAITING;
							rec_new.period = per_q;
							rec_new.delay  = fd_q;
						end
					end
					ACT_DELETE, ACT_SUSPEND, ACT_RESUME: begin
						if (!found_q && (rec.id == id_q)) begin
							hit    = 1'b1;
							ram_we = 1'b1;
							case (act_q)
								ACT_DELETE:  rec_new.used = 1'b0;
								ACT_SUSPEND: rec_new.st   = SLOT_SUSPENDED;
								default:     rec_new.st   = SLOT_READY;
							endcase
						end
					end
					ACT_TICK: begin
						if (rec.used && (rec.st == SLOT_READY)) begin
							hit           = 1'b1;
							ram_we        = 1'b1;
							rec_new.delay = alu_rsp.diff;
							rec_new.st    = SLOT_WAITING;
							// An earlier dispatch leaves now; it was not the last one.
							emit_held     = held_valid_q;
						end else if (rec.used && (rec.st == SLOT_WAITING)) begin
							ram_we        = 1'b1;
							rec_new.delay = alu_rsp.diff;
							rec_new.st    = alu_rsp.zero ? SLOT_READY : SLOT_WAITING;
						end
					end
					default: begin
					end
				endcase
				if (emit_held) begin
					beat_valid      = 1'b1;
					beat.dispatched = 1'b1;
					beat.run_id     = held_id_q;
					beat.run_level  = RUN_LVL_W'(held_lvl_q);
					beat.run_slot   = RUN_SLOT_W'(held_sl_q);
					beat.last       = 1'b0;
				end
				// The scan freezes while an earlier dispatch waits for the output.
				scan_go = !(emit_held && !beat_take);
				ram_we  = ram_we && scan_go;
				ram_re  = scan_go && !scan_last;
			end
			S_PEND: begin
				beat_valid = 1'b1;
				if (rec.used) begin
					ram_we          = beat_take;
					rec_new.delay   = alu_rsp.diff;
					rec_new.st      = SLOT_WAITING;
					beat.dispatched = 1'b1;
					beat.run_id     = rec.id;
					beat.run_level  = RUN_LVL_W'(lvl_q);
					beat.run_slot   = RUN_SLOT_W'(sl_q);
				end
			end
			S_TICK_END: begin
				beat_valid = 1'b1;
				if (held_valid_q) begin
					beat.dispatched = 1'b1;
					beat.run_id     = held_id_q;
					beat.run_level  = RUN_LVL_W'(held_lvl_q);
					beat.run_slot   = RUN_SLOT_W'(held_sl_q);
				end
			end
			S_REPLY: begin
				beat_valid  = 1'b1;
				beat.status = status_q;
			end
			default: begin
			end
		endcase
	end

	// Sequencer state, scan position and scheduler registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			act_q           <= '0;
			id_q            <= '0;
			per_q           <= '0;
			fd_q            <= '0;
			status_q        <= STATUS_OK;
			idx_q           <= '0;
			lvl_q           <= '0;
			sl_q            <= '0;
			found_q         <= 1'b0;
			running_level_q <= '0;
			pend_valid_q    <= 1'b0;
			pend_idx_q      <= '0;
			pend_lvl_q      <= '0;
			pend_sl_q       <= '0;
			held_valid_q    <= 1'b0;
			held_id_q       <= '0;
			held_lvl_q      <= '0;
			held_sl_q       <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						act_q    <= action;
						id_q     <= task_id;
						per_q    <= period;
						fd_q     <= first_delay;
						status_q <= STATUS_OK;
						idx_q    <= start_idx;
						lvl_q    <= '0;
						sl_q     <= '0;
						found_q  <= 1'b0;
						case (action)
							ACT_ADD: begin
								status_q <= STATUS_NOT_ADDED;
								state_q  <= prio_ok ? S_SCAN : S_REPLY;
							end
							ACT_DELETE, ACT_SUSPEND, ACT_RESUME: begin
								state_q <= S_SCAN;
							end
							ACT_TICK: begin
								if (pend_valid_q) begin
									pend_valid_q <= 1'b0;
									lvl_q        <= pend_lvl_q;
									sl_q         <= pend_sl_q;
									state_q      <= S_PEND;
								end else begin
									state_q <= S_SCAN;
								end
							end
							default: begin
								state_q <= S_REPLY;
							end
						endcase
					end
				end
				S_SCAN: begin
					if (scan_go) begin
						// Step to the next slot or finish the walk.
						if (scan_last) begin
							state_q <= (act_q == ACT_TICK) ? S_TICK_END : S_REPLY;
						end else begin
							idx_q <= IW'(idx_q + IW'(1));
							if (sl_q == SL_LAST) begin
								sl_q  <= '0;
								lvl_q <= LW'(lvl_q + LW'(1));
							end else begin
								sl_q <= SW'(sl_q + SW'(1));
							end
						end
						case (act_q)
							ACT_ADD: begin
								if (hit) begin
									status_q <= STATUS_OK;
									state_q  <= S_REPLY;
								end
							end
							ACT_DELETE, ACT_SUSPEND, ACT_RESUME: begin
								found_q <= (sl_q == SL_LAST) ? 1'b0 : (found_q || hit);
								if (hit && (act_q == ACT_RESUME) && preempt &&
										(lvl_q < running_level_q)) begin
									pend_valid_q <= 1'b1;
									pend_idx_q   <= idx_q;
									pend_lvl_q   <= lvl_q;
									pend_sl_q    <= sl_q;
								end
							end
							ACT_TICK: begin
								if (hit) begin
									running_level_q <= lvl_q;
									held_valid_q    <= 1'b1;
									held_id_q       <= rec.id;
									held_lvl_q      <= lvl_q;
									held_sl_q       <= sl_q;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_PEND: begin
					if (beat_take) begin
						state_q <= S_IDLE;
					end
				end
				S_TICK_END: begin
					if (beat_take) begin
						held_valid_q <= 1'b0;
						state_q      <= S_IDLE;
					end
				end
				S_REPLY: begin
					if (beat_take) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Written marks for the slot memory and the mark of the entry being read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NSLOT; i++) begin
				wr_q[i] <= 1'b0;
			end
			rd_wr_q <= 1'b0;
		end else begin
			if (ram_we) begin
				wr_q[ram_waddr] <= 1'b1;
			end
			if (ram_re) begin
				rd_wr_q <= wr_q[ram_raddr];
			end
		end
	end

	`PPTS_ASSERT_NEXT(a_last_beat_idle, clk, arst_n, beat_valid && beat_take && beat.last, state_q == S_IDLE, "Final beat taken but sequencer did not return to idle")
	`PPTS_ASSERT_HOLDS(a_dispatch_ok, clk, arst_n, beat_valid && beat.dispatched, beat.status == STATUS_OK, "Dispatch beat carries a not-added status")
	`PPTS_ASSERT_HOLDS(a_write_when_busy, clk, arst_n, ram_we, state_q == S_SCAN || state_q == S_PEND, "Slot memory written outside a scan")
	`PPTS_ASSERT_HOLDS(a_scan_freeze, clk, arst_n, state_q == S_SCAN && beat_valid && !beat_take, !ram_we && !ram_re, "Scan advanced while a dispatch beat was blocked")
	`PPTS_ASSERT_HOLDS(a_pend_preempt, clk, arst_n, $rose(pend_valid_q), $past(preempt), "Pending dispatch recorded without preemptive mode")

endmodule

>>> rtl/priority_periodic_task_scheduler.sv
// Priority periodic task scheduler.
//
// Commands enter on the cmd channel (cmd_valid / cmd_stall): add, delete,
// suspend, resume and tick. Results leave on the rsp channel (rsp_valid /
// rsp_stall), one beat per command, or on a tick one per dispatched task
// or one if none; the final beat of a command has last set. The cfg channel
// (cfg_valid / cfg_ready, always ready) writes tick_step and preemptive mode
// and is meant to be used only while no command is in flight.
//
// The slot table is walked one slot per cycle, unless a dispatch beat is
// blocked, through a single slot memory with a registered read port and one
// shared subtractor. Delete, suspend, resume and tick walk the whole table
// (LEVELS*SLOTS slots), add walks at most the SLOTS slots of its priority
// level, and a pending preemptive tick, an invalid add or an unused code
// walks no slot; cmd_stall stays high until the final beat of the command
// is taken. A stalled output holds its beat in the output register; a tick
// walk pauses on the next dispatch until the earlier dispatch beat has left.
// Reset empties the table, clears the pending dispatch and sets tick_step to
// 1 and preemptive mode off.
// Depends on ppts_pkg, ppts_ram, ppts_alu and ppts_ctrl.
module priority_periodic_task_scheduler import ppts_pkg::*; #(
	parameter int LEVELS = DEF_LEVELS,
	parameter int SLOTS  = DEF_SLOTS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// Command channel
	input  logic                  cmd_valid,
	output logic                  cmd_stall,
	input  logic [ACTION_W-1:0]   action,
	input  logic [ID_W-1:0]       task_id,
	input  logic [PRIO_W-1:0]     priority_req,
	input  logic [TIME_W-1:0]     period,
	input  logic [TIME_W-1:0]     first_delay,
	// Configuration channel
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	// Result channel
	output logic                  rsp_valid,
	input  logic                  rsp_stall,
	output logic                  status,
	output logic                  dispatched,
	output logic [ID_W-1:0]       run_id,
	output logic [RUN_LVL_W-1:0]  run_level,
	output logic [RUN_SLOT_W-1:0] run_slot,
	output logic                  last
);

	localparam int NSLOT = LEVELS * SLOTS;
	localparam int IW    = (NSLOT > 1) ? $clog2(NSLOT) : 1;

	logic [STEP_W-1:0] tick_step_q;
	logic              preempt_q;
	logic              rsp_valid_q;
	rsp_beat_t         rsp_q;

	logic              beat_valid;
	rsp_beat_t         beat;
	logic              beat_take;
	logic              ram_we;
	logic [IW-1:0]     ram_waddr;
	logic [REC_W-1:0]  ram_wdata;
	logic              ram_re;
	logic [IW-1:0]     ram_raddr;
	logic [REC_W-1:0]  ram_rdata;
	alu_req_t          alu_req;
	alu_rsp_t          alu_rsp;

	// Configuration registers.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_step_q <= TICK_STEP_RST;
			preempt_q   <= PREEMPT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_TICK_STEP: tick_step_q <= cfg_data;
				CFG_PREEMPT:   preempt_q   <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// Sequencer with the slot memory and the shared subtractor.
	ppts_ctrl #(
		.LEVELS(LEVELS),
		.SLOTS (SLOTS)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (cmd_valid),
		.cmd_stall   (cmd_stall),
		.action      (action),
		.task_id     (task_id),
		.priority_req(priority_req),
		.period      (period),
		.first_delay (first_delay),
		.tick_step   (tick_step_q),
		.preempt     (preempt_q),
		.beat_valid  (beat_valid),
		.beat        (beat),
		.beat_take   (beat_take),
		.ram_we      (ram_we),
		.ram_waddr   (ram_waddr),
		.ram_wdata   (ram_wdata),
		.ram_re      (ram_re),
		.ram_raddr   (ram_raddr),
		.ram_rdata   (ram_rdata),
		.alu_req     (alu_req),
		.alu_rsp     (alu_rsp)
	);

	ppts_ram #(
		.WIDTH(REC_W),
		.DEPTH(NSLOT)
	) u_slot_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	ppts_alu u_alu (
		.req(alu_req),
		.rsp(alu_rsp)
	);

	// Output register: takes a beat when empty or when the held one leaves.
	assign beat_take = beat_valid && (!rsp_valid_q || !rsp_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (beat_take) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (beat_take) begin
			rsp_q <= beat;
		end
	end

	assign rsp_valid  = rsp_valid_q;
	assign status     = rsp_q.status;
	assign dispatched = rsp_q.dispatched;
	assign run_id     = rsp_q.run_id;
	assign run_level  = rsp_q.run_level;
	assign run_slot   = rsp_q.run_slot;
	assign last       = rsp_q.last;

endmodule
